### hw/rtl/dipa_pkg.sv
package dipa_pkg;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned ID_W    = 8;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 32;

	typedef enum logic [KIND_W-1:0] {
		K_ALLOC   = 2'd0,
		K_RELEASE = 2'd1,
		K_NEXT    = 2'd2,
		K_QUERY   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ALLOC_WR,
		S_NEXT_DONE,
		S_CHECK_POS,
		S_CHECK_DENSE,
		S_REL_SWAP,
		S_REL_FILL,
		S_RESULT
	} state_t;

	// dense list read address source
	typedef enum logic [1:0] {
		DS_USED,
		DS_CURSOR,
		DS_HOLE,
		DS_LAST
	} dsel_t;

	// how the pending result register is loaded
	typedef enum logic [2:0] {
		R_HOLD,
		R_FAIL,
		R_DONE,
		R_ALLOC,
		R_QUERY,
		R_NEXT
	} res_t;

	typedef struct packed {
		logic  capture;
		logic  pos_rd;
		logic  dense_rd;
		dsel_t dense_sel;
		logic  cursor_adv;
		logic  latch_hole;
		logic  alloc_commit;
		logic  swap_first;
		logic  swap_fill;
		logic  dec_used;
		res_t  res;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  empty;
		logic  id_known;
		logic  hole_ok;
		logic  match;
		logic  last_is_hole;
		logic  out_free;
	} status_t;

endpackage

### hw/rtl/dense_id_pool_allocator_unit.sv
// Channel   Dir  Bus                  Contents
// s_axis    in   tuser[1:0]           kind (allocate, release, next, query)
//                tdata[7:0]           item_id
// m_axis    out  tdata[31:0]          ok, id_out, position, used_count, zero pad
//
// One request at a time. A request refused at decode goes straight to its result step;
// allocate and next read the dense table; query and release read the position, then the
// dense entry (a stale id fails at either check), and a release whose hole is not last
// swaps with two dense writes. Each table has a single read port and a registered read.
// Reset clears the counters only; the tables are never swept: a high-water mark
// on each table stands in for entries not yet written, so no clearing pass.
// The output register lets a new request in while the last result waits;
// a finished request stalls in its result step until that register frees.
module dense_id_pool_allocator_unit import dipa_pkg::*; #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] item_id
	input  logic [KIND_W-1:0]      s_axis_tuser,  // [1:0] kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] ok, [8:1] id_out,
	                                              // [16:9] position,
	                                              // [25:17] used_count
);

	localparam int unsigned PAD_W = OUT_TDATA_W - 1 - ID_W - POS_W - COUNT_W;

	cmd_t               cmd;
	status_t            status;
	logic               out_ok;
	logic [ID_W-1:0]    out_id;
	logic [POS_W-1:0]   out_pos;
	logic [COUNT_W-1:0] out_used;

	dipa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dipa_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.kind_in   (s_axis_tuser),
		.item_id_in(s_axis_tdata[ID_W-1:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ok    (out_ok),
		.out_id    (out_id),
		.out_pos   (out_pos),
		.out_used  (out_used)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, out_used, out_pos, out_id, out_ok};

endmodule

### hw/rtl/dipa_ram.sv
module dipa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/dipa_ctrl.sv
module dipa_ctrl import dipa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.res   = R_HOLD;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.kind) inside
					K_ALLOC: begin
						if (status.full) begin
							cmd.res = R_FAIL;
							state_d = S_RESULT;
						end else begin
							cmd.dense_rd  = 1'b1;
							cmd.dense_sel = DS_USED;
							state_d       = S_ALLOC_WR;
						end
					end
					K_NEXT: begin
						if (status.empty) begin
							cmd.res = R_FAIL;
							state_d = S_RESULT;
						end else begin
							cmd.dense_rd   = 1'b1;
							cmd.dense_sel  = DS_CURSOR;
							cmd.cursor_adv = 1'b1;
							state_d        = S_NEXT_DONE;
						end
					end
					K_RELEASE, K_QUERY: begin
						if (!status.id_known) begin
							cmd.res = R_FAIL;
							state_d = S_RESULT;
						end else begin
							cmd.pos_rd = 1'b1;
							state_d    = S_CHECK_POS;
						end
					end
					default: begin
						cmd.res = R_FAIL;
						state_d = S_RESULT;
					end
				endcase
			end
			S_ALLOC_WR: begin
				cmd.alloc_commit = 1'b1;
				cmd.res          = R_ALLOC;
				state_d          = S_RESULT;
			end
			S_NEXT_DONE: begin
				cmd.res = R_NEXT;
				state_d = S_RESULT;
			end
			S_CHECK_POS: begin
				cmd.latch_hole = 1'b1;
				if (!status.hole_ok) begin
					cmd.res = R_FAIL;
					state_d = S_RESULT;
				end else begin
					// confirm the id really sits at that position
					cmd.dense_rd  = 1'b1;
					cmd.dense_sel = DS_HOLE;
					state_d       = S_CHECK_DENSE;
				end
			end
			S_CHECK_DENSE: begin
				if (!status.match) begin
					cmd.res = R_FAIL;
					state_d = S_RESULT;
				end else if (status.kind == K_QUERY) begin
					cmd.res = R_QUERY;
					state_d = S_RESULT;
				end else if (status.last_is_hole) begin
					cmd.dec_used = 1'b1;
					cmd.res      = R_DONE;
					state_d      = S_RESULT;
				end else begin
					cmd.dense_rd  = 1'b1;
					cmd.dense_sel = DS_LAST;
					state_d       = S_REL_SWAP;
				end
			end
			S_REL_SWAP: begin
				cmd.swap_first = 1'b1;
				state_d        = S_REL_FILL;
			end
			S_REL_FILL: begin
				cmd.swap_fill = 1'b1;
				cmd.dec_used  = 1'b1;
				cmd.res       = R_DONE;
				state_d       = S_RESULT;
			end
			S_RESULT: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/dipa_datapath.sv
module dipa_datapath import dipa_pkg::*; #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [KIND_W-1:0]  kind_in,
	input  logic [ID_W-1:0]    item_id_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_ok,
	output logic [ID_W-1:0]    out_id,
	output logic [POS_W-1:0]   out_pos,
	output logic [COUNT_W-1:0] out_used
);

	localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = (PW > ID_W) ? PW : ID_W;
	localparam int unsigned KW = (IW > CW) ? IW : CW;
	localparam int unsigned UW = (CW > COUNT_W) ? CW : COUNT_W;

	// counters
	logic [CW-1:0] used_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] hw_q;     // ids below this have a written position entry
	logic [CW-1:0] dw_q;     // dense positions at or above this still hold their own index

	// request and working registers
	kind_t         kind_q;
	logic [IW-1:0] id_q;
	logic [PW-1:0] hole_q;
	logic [PW-1:0] moved_q;
	logic [PW-1:0] dense_addr_q;
	logic          dense_ident_q;

	// pending result
	logic          res_ok_q;
	logic [PW-1:0] res_id_q;
	logic [PW-1:0] res_pos_q;

	// output register
	logic               out_valid_q;
	logic               out_ok_q;
	logic [ID_W-1:0]    out_id_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [COUNT_W-1:0] out_used_q;

	logic [CW-1:0] cursor_eff;
	logic [CW-1:0] last_c;
	logic [PW-1:0] dense_raddr;
	logic [PW-1:0] dense_rdata;
	logic [PW-1:0] dense_val;
	logic [PW-1:0] pos_rdata;
	logic          dense_we;
	logic [PW-1:0] dense_waddr;
	logic [PW-1:0] dense_wdata;
	logic          pos_we;
	logic [PW-1:0] pos_waddr;
	logic [PW-1:0] pos_wdata;
	logic [PW-1:0] alloc_id;
	logic [IW-1:0] id_wide;
	logic [IW-1:0] pos_wide;
	logic [UW-1:0] used_wide;
	logic          out_free;

	assign cursor_eff = (cursor_q >= used_q) ? '0 : cursor_q;
	assign last_c     = used_q - CW'(1);
	assign dense_val  = dense_ident_q ? dense_addr_q : dense_rdata;
	assign alloc_id   = dense_val;
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		unique case (cmd.dense_sel)
			DS_USED:   dense_raddr = used_q[PW-1:0];
			DS_CURSOR: dense_raddr = cursor_eff[PW-1:0];
			DS_HOLE:   dense_raddr = pos_rdata;
			DS_LAST:   dense_raddr = last_c[PW-1:0];
			default:   dense_raddr = '0;
		endcase
	end

	always_comb begin
		dense_we    = 1'b0;
		dense_waddr = hole_q;
		dense_wdata = moved_q;
		if (cmd.alloc_commit) begin
			// write back so every position below the peak count holds real data
			dense_we    = 1'b1;
			dense_waddr = used_q[PW-1:0];
			dense_wdata = alloc_id;
		end else if (cmd.swap_first) begin
			dense_we    = 1'b1;
			dense_waddr = last_c[PW-1:0];
			dense_wdata = id_q[PW-1:0];
		end else if (cmd.swap_fill) begin
			dense_we = 1'b1;
		end
	end

	always_comb begin
		pos_we    = 1'b0;
		pos_waddr = alloc_id;
		pos_wdata = used_q[PW-1:0];
		if (cmd.alloc_commit) begin
			pos_we = 1'b1;
		end else if (cmd.swap_first) begin
			pos_we    = 1'b1;
			pos_waddr = dense_val;
			pos_wdata = hole_q;
		end
	end

	dipa_ram #(
		.WIDTH(PW),
		.DEPTH(CAPACITY)
	) u_dense_ram (
		.clk  (clk),
		.we   (dense_we),
		.waddr(dense_waddr),
		.wdata(dense_wdata),
		.re   (cmd.dense_rd),
		.raddr(dense_raddr),
		.rdata(dense_rdata)
	);

	dipa_ram #(
		.WIDTH(PW),
		.DEPTH(CAPACITY)
	) u_pos_ram (
		.clk  (clk),
		.we   (pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.re   (cmd.pos_rd),
		.raddr(id_q[PW-1:0]),
		.rdata(pos_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			cursor_q    <= '0;
			hw_q        <= '0;
			dw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.alloc_commit) begin
				used_q <= used_q + CW'(1);
				if (used_q == hw_q) begin
					hw_q <= hw_q + CW'(1);
				end
			end else if (cmd.dec_used) begin
				used_q <= last_c;
			end
			if (cmd.cursor_adv) begin
				cursor_q <= cursor_eff + CW'(1);
			end
			// the swap writes the last position, which lies above the hole
			if (cmd.swap_first && (used_q > dw_q)) begin
				dw_q <= used_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign id_wide   = IW'(res_id_q);
	assign pos_wide  = IW'(res_pos_q);
	assign used_wide = UW'(used_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind_t'(kind_in);
			id_q   <= IW'(item_id_in);
		end
		if (cmd.dense_rd) begin
			dense_addr_q  <= dense_raddr;
			dense_ident_q <= CW'(dense_raddr) >= dw_q;
		end
		if (cmd.latch_hole) begin
			hole_q <= pos_rdata;
		end
		if (cmd.swap_first) begin
			moved_q <= dense_val;
		end
		unique case (cmd.res)
			R_HOLD: begin
			end
			R_FAIL: begin
				res_ok_q  <= 1'b0;
				res_id_q  <= '0;
				res_pos_q <= '0;
			end
			R_DONE: begin
				res_ok_q  <= 1'b1;
				res_id_q  <= '0;
				res_pos_q <= '0;
			end
			R_ALLOC: begin
				res_ok_q  <= 1'b1;
				res_id_q  <= alloc_id;
				res_pos_q <= '0;
			end
			R_QUERY: begin
				res_ok_q  <= 1'b1;
				res_id_q  <= '0;
				res_pos_q <= hole_q;
			end
			R_NEXT: begin
				res_ok_q  <= 1'b1;
				res_id_q  <= dense_val;
				res_pos_q <= '0;
			end
			default: begin
			end
		endcase
		if (cmd.emit) begin
			out_ok_q   <= res_ok_q;
			out_id_q   <= id_wide[ID_W-1:0];
			out_pos_q  <= pos_wide[POS_W-1:0];
			out_used_q <= used_wide[COUNT_W-1:0];
		end
	end

	always_comb begin
		status.kind         = kind_q;
		status.full         = (used_q == CW'(CAPACITY));
		status.empty        = (used_q == '0);
		status.id_known     = (KW'(id_q) < KW'(hw_q));
		status.hole_ok      = (CW'(pos_rdata) < used_q);
		status.match        = (IW'(dense_val) == id_q);
		status.last_is_hole = (last_c[PW-1:0] == hole_q);
		status.out_free     = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_ok    = out_ok_q;
	assign out_id    = out_id_q;
	assign out_pos   = out_pos_q;
	assign out_used  = out_used_q;

endmodule

### hw/rtl/dipa_checker.sv
module dipa_checker import dipa_pkg::*; #(
	parameter int unsigned CAPACITY = 256
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed or dropped");

	// one request in flight: ready drops right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while another is in work");

	// a failed request carries no id and no position
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[16:1] == '0))
		else $error("failed result with nonzero id or position");

	// the used count never exceeds the pool
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata[25:17]) <= CAPACITY))
		else $error("used count above capacity");

endmodule

bind dense_id_pool_allocator_unit dipa_checker #(
	.CAPACITY(CAPACITY)
) u_dipa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
